// File: rtl/core/rpkc_pkg.sv
// shared types, sizes and helpers for the repeated-pattern kmp check
package rpkc_pkg;

  localparam int MAX_LEN  = 1024;
  localparam int ADDR_W   = $clog2(MAX_LEN);
  localparam int CNT_W    = $clog2(MAX_LEN + 1);
  localparam int PERIOD_W = 11;
  localparam int CHAR_W   = 8;
  localparam int DIV_CNT_W = $clog2(CNT_W + 1);

  typedef struct packed {
    logic [CHAR_W-1:0] char_in;
    logic              last_char;
  } rpkc_in_t;

  typedef struct packed {
    logic                is_repeated;
    logic [PERIOD_W-1:0] period;
    logic                overflowed;
  } rpkc_out_t;

  // request to the remainder unit
  typedef struct packed {
    logic             start;
    logic [CNT_W-1:0] dividend;
    logic [CNT_W-1:0] divisor;
  } rpkc_div_req_t;

  // answer from the remainder unit
  typedef struct packed {
    logic done;
    logic rem_zero;
  } rpkc_div_rsp_t;

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_EVAL   = 4'b0010,
    S_DIV    = 4'b0100,
    S_RESULT = 4'b1000
  } rpkc_state_t;

  // fit a length-sized value into the period field, masking or zero extending
  function automatic logic [PERIOD_W-1:0] to_period(input logic [CNT_W-1:0] v);
    logic [CNT_W+PERIOD_W-1:0] w;
    w = {{PERIOD_W{1'b0}}, v};
    return w[PERIOD_W-1:0];
  endfunction

endpackage

// File: rtl/core/repeated_pattern_kmp_check_core.sv
// top level: kmp prefix table builder and repeated-substring check
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+-------------------------------------
//  in      | input     | in_valid/in_ready  | in_data: char_in, last_char
//  out     | output    | out_valid/out_ready| out_data: is_repeated, period, overflowed
//
// sequence: a byte is accepted with a memory read, then evaluated and written
//   back after any kmp fallback steps; each step is one read of both memories.
//   the last byte of a string then runs the bit-serial remainder test and
//   loads the output register; an overflowed string skips the remainder test.
// reset: clears the run state (match length, position, overflow) and the
//   control; the byte and prefix memories are not cleared, since a string
//   reads only entries it wrote itself.
// stalls: the result sits in an output register; the next string is taken
//   while it waits, and only a later result waits for that register to free.
module repeated_pattern_kmp_check_core
  import rpkc_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  rpkc_in_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output rpkc_out_t out_data
);

  // control and run state
  rpkc_state_t       state_r, state_nxt;
  logic [ADDR_W-1:0] ml_r, ml_nxt;          // running match length
  logic [CNT_W-1:0]  pos_r, pos_nxt;        // bytes stored so far
  logic              ovf_r, ovf_nxt;

  // current transaction
  logic [CHAR_W-1:0] c_r, c_nxt;
  logic              last_r, last_nxt;

  // pending result
  logic              res_ovf_r, res_ovf_nxt;
  logic [CNT_W-1:0]  res_per_r, res_per_nxt;
  logic              res_mlnz_r, res_mlnz_nxt;
  logic              rep_r, rep_nxt;

  // output register
  logic              out_valid_r, out_valid_nxt;
  rpkc_out_t         out_data_r, out_data_nxt;

  // memory ports
  logic [CHAR_W-1:0] store_rdata;
  logic [ADDR_W-1:0] table_rdata;
  logic [ADDR_W-1:0] rd_addr;
  logic [ADDR_W-1:0] tbl_rd_addr;
  logic [ADDR_W-1:0] wr_addr;
  logic              wr_en;

  // evaluate-cycle decode
  logic              skip;       // string full or already past the length limit
  logic              hit;
  logic              walk;       // mismatch, fall back through the table
  logic              eval_done;
  logic [ADDR_W-1:0] ml_fin;
  logic [CNT_W-1:0]  pos_inc;
  logic [CNT_W-1:0]  per_fin;

  rpkc_div_req_t     div_req;
  rpkc_div_rsp_t     div_rsp;

  assign skip      = ovf_r || (pos_r == CNT_W'(MAX_LEN));
  assign hit       = (c_r == store_rdata);
  assign walk      = (state_r == S_EVAL) && !skip && (pos_r != '0) &&
                     (ml_r != '0) && !hit;
  assign eval_done = (state_r == S_EVAL) && !walk;
  assign ml_fin    = (pos_r == '0) ? '0 : ml_r + ADDR_W'(hit);
  assign pos_inc   = pos_r + CNT_W'(1);
  assign per_fin   = pos_inc - CNT_W'(ml_fin);

  // a fallback step reads the byte and prefix entries of the new match length
  assign rd_addr     = walk ? table_rdata : ml_r;
  assign tbl_rd_addr = rd_addr - ADDR_W'(1);
  assign wr_en       = eval_done && !skip;
  assign wr_addr     = pos_r[ADDR_W-1:0];

  assign div_req.start    = eval_done && last_r && !skip;
  assign div_req.dividend = pos_inc;
  assign div_req.divisor  = per_fin;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  rpkc_ram #(
    .WIDTH (CHAR_W),
    .DEPTH (MAX_LEN)
  ) u_char_store (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_addr),
    .wdata (c_r),
    .raddr (rd_addr),
    .rdata (store_rdata)
  );

  rpkc_ram #(
    .WIDTH (ADDR_W),
    .DEPTH (MAX_LEN)
  ) u_prefix_table (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_addr),
    .wdata (ml_fin),
    .raddr (tbl_rd_addr),
    .rdata (table_rdata)
  );

  rpkc_rem_unit u_rem (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  always_comb begin
    state_nxt     = state_r;
    ml_nxt        = ml_r;
    pos_nxt       = pos_r;
    ovf_nxt       = ovf_r;
    c_nxt         = c_r;
    last_nxt      = last_r;
    res_ovf_nxt   = res_ovf_r;
    res_per_nxt   = res_per_r;
    res_mlnz_nxt  = res_mlnz_r;
    rep_nxt       = rep_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;

    case (state_r)
      S_IDLE: begin
        // memory reads at the match length are issued in this cycle
        if (in_valid) begin
          c_nxt     = in_data.char_in;
          last_nxt  = in_data.last_char;
          state_nxt = S_EVAL;
        end
      end
      S_EVAL: begin
        if (walk) begin
          ml_nxt = table_rdata;
        end else begin
          if (skip) begin
            ovf_nxt = 1'b1;
          end else begin
            ml_nxt  = ml_fin;
            pos_nxt = pos_inc;
          end
          if (last_r) begin
            res_ovf_nxt  = skip;
            res_per_nxt  = per_fin;
            res_mlnz_nxt = (ml_fin != '0);
            // start over for the next string
            ml_nxt       = '0;
            pos_nxt      = '0;
            ovf_nxt      = 1'b0;
            state_nxt    = skip ? S_RESULT : S_DIV;
          end else begin
            state_nxt = S_IDLE;
          end
        end
      end
      S_DIV: begin
        if (div_rsp.done) begin
          rep_nxt   = res_mlnz_r && div_rsp.rem_zero;
          state_nxt = S_RESULT;
        end
      end
      S_RESULT: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt            = 1'b1;
          out_data_nxt.overflowed  = res_ovf_r;
          out_data_nxt.is_repeated = !res_ovf_r && rep_r;
          out_data_nxt.period      = res_ovf_r ? '0 : to_period(res_per_r);
          state_nxt                = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      ml_r        <= '0;
      pos_r       <= '0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      ml_r        <= ml_nxt;
      pos_r       <= pos_nxt;
      ovf_r       <= ovf_nxt;
      out_valid_r <= out_valid_nxt;
    end
    c_r        <= c_nxt;
    last_r     <= last_nxt;
    res_ovf_r  <= res_ovf_nxt;
    res_per_r  <= res_per_nxt;
    res_mlnz_r <= res_mlnz_nxt;
    rep_r      <= rep_nxt;
    out_data_r <= out_data_nxt;
  end

  // match length stays below the stored length once a byte is stored
  a_ml_below_pos: assert property (@(posedge clk) disable iff (!rst_n)
    (ml_r < ADDR_W'(pos_r)) || (pos_r == CNT_W'(MAX_LEN)) ||
    ((ml_r == '0) && (pos_r == '0)))
    else $error("match length not below position");

  // position never passes the length limit
  a_pos_limit: assert property (@(posedge clk) disable iff (!rst_n)
    pos_r <= CNT_W'(MAX_LEN))
    else $error("position beyond limit");

  // an overflowed string reports a zero period and no repeat
  a_ovf_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r.overflowed |->
      (out_data_r.period == '0) && !out_data_r.is_repeated)
    else $error("overflow result fields wrong");

  // the remainder unit answers only while a string end waits for it
  a_div_state: assert property (@(posedge clk) disable iff (!rst_n)
    div_rsp.done |-> (state_r == S_DIV))
    else $error("remainder done outside divide state");

endmodule

// File: rtl/core/rpkc_ram.sv
// generic simple dual-port ram with registered read
module rpkc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/core/rpkc_rem_unit.sv
// bit-serial restoring remainder unit, one quotient bit per cycle
module rpkc_rem_unit
  import rpkc_pkg::*;
(
  input  logic          clk,
  input  logic          rst_n,
  input  rpkc_div_req_t req,
  output rpkc_div_rsp_t rsp
);

  logic [CNT_W-1:0]     rem_r, rem_nxt;
  logic [CNT_W-1:0]     dvd_r, dvd_nxt;
  logic [CNT_W-1:0]     dsr_r, dsr_nxt;
  logic [DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic                 busy_r, busy_nxt;
  logic                 done_r, done_nxt;
  logic [CNT_W:0]       shifted;

  always_comb begin
    shifted  = {rem_r, dvd_r[CNT_W-1]};
    rem_nxt  = rem_r;
    dvd_nxt  = dvd_r;
    dsr_nxt  = dsr_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (req.start) begin
      rem_nxt  = '0;
      dvd_nxt  = req.dividend;
      dsr_nxt  = req.divisor;
      cnt_nxt  = DIV_CNT_W'(CNT_W);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      // trial subtract
      if (shifted >= {1'b0, dsr_r}) begin
        rem_nxt = CNT_W'(shifted - {1'b0, dsr_r});
      end else begin
        rem_nxt = shifted[CNT_W-1:0];
      end
      dvd_nxt = {dvd_r[CNT_W-2:0], 1'b0};
      cnt_nxt = cnt_r - DIV_CNT_W'(1);
      if (cnt_r == DIV_CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    dvd_r <= dvd_nxt;
    dsr_r <= dsr_nxt;
  end

  assign rsp.done     = done_r;
  assign rsp.rem_zero = (rem_r == '0);

endmodule
